FILE: hdl/aes256cfb_pkg.sv
// ----------------------------------------------------------------------------
// AES-256 CFB package
// Shared types, constants and the AES byte functions.
// ----------------------------------------------------------------------------
package aes256cfb_pkg;

  localparam int unsigned Rounds = 14;
  localparam int unsigned RkDepth = 2 * (Rounds + 1);
  localparam int unsigned DigitW = 8;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_IVH  = 3'd4,
    REG_IVL  = 3'd5,
    REG_MODE = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_ROUND,
    ST_OUT
  } state_e;

  // passes within ST_ROUND
  typedef enum logic [2:0] {
    PH_FETCH,
    PH_ARK,
    PH_SUB,
    PH_MIX,
    PH_KEY,
    PH_DONE
  } phase_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

FILE: hdl/aes256cfb_ram.sv
// ----------------------------------------------------------------------------
// AES-256 CFB generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aes256cfb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/aes256_cfb_cipher_unit.sv
// ----------------------------------------------------------------------------
// AES-256 CFB cipher unit
// Full-block CFB mode over a byte-serial AES-256 core.
// ----------------------------------------------------------------------------
// One block is processed at a time. The AES state is a ring of 16 byte
// registers that rotates one byte per cycle through a single S-box, and a
// whole column at a time in MixColumns. Round 0 is an AddRoundKey pass after
// a key fetch; each of rounds 1 to 13 runs SubBytes+ShiftRows, MixColumns, a
// key fetch and AddRoundKey; the last round skips MixColumns. The result is
// then formed and offered. A first block also runs the key expansion first,
// one 32-bit key word per cycle through a 32-bit S-box word path. The round
// keys live in a 30 x 64 RAM. The result sits in an output register and is
// held until taken; the next transaction is accepted after that.
module aes256_cfb_cipher_unit #(
  parameter int unsigned Rounds = aes256cfb_pkg::Rounds
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [5:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  aes256cfb_pkg::in_item_t    in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output aes256cfb_pkg::out_item_t   out_data_o
);

  localparam int unsigned RkDepth = 2 * (Rounds + 1);
  localparam int unsigned RkAw = $clog2(RkDepth);
  localparam int unsigned WordCnt = 4 * (Rounds + 1);
  localparam int unsigned RndW = $clog2(Rounds + 1);

  // configuration
  logic [63:0] key_q [4];
  logic [63:0] ivh_q, ivl_q;
  logic        mode_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      ivh_q  <= '0;
      ivl_q  <= '0;
      mode_q <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        aes256cfb_pkg::REG_KEY0: key_q[0] <= pwdata;
        aes256cfb_pkg::REG_KEY1: key_q[1] <= pwdata;
        aes256cfb_pkg::REG_KEY2: key_q[2] <= pwdata;
        aes256cfb_pkg::REG_KEY3: key_q[3] <= pwdata;
        aes256cfb_pkg::REG_IVH:  ivh_q    <= pwdata;
        aes256cfb_pkg::REG_IVL:  ivl_q    <= pwdata;
        aes256cfb_pkg::REG_MODE: mode_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      aes256cfb_pkg::REG_KEY0: prdata = key_q[0];
      aes256cfb_pkg::REG_KEY1: prdata = key_q[1];
      aes256cfb_pkg::REG_KEY2: prdata = key_q[2];
      aes256cfb_pkg::REG_KEY3: prdata = key_q[3];
      aes256cfb_pkg::REG_IVH:  prdata = ivh_q;
      aes256cfb_pkg::REG_IVL:  prdata = ivl_q;
      aes256cfb_pkg::REG_MODE: prdata = {63'd0, mode_q};
      default:                 prdata = '0;
    endcase
  end

  // datapath registers
  aes256cfb_pkg::state_e state_q, state_d;
  logic [7:0]   st_q [16];       // AES state ring, byte 0 at head
  logic [63:0]  fbh_q, fbl_q;    // feedback
  logic [63:0]  blkh_q, blkl_q;  // input block
  logic [63:0]  resh_q, resl_q;
  logic [3:0]   bcnt_q;          // byte counter in a pass
  aes256cfb_pkg::phase_e ph_q;
  logic [RndW-1:0] rnd_q;

  // key expansion: sliding window of 8 words, one word per step
  logic [31:0]  kw_q [8];
  logic [$clog2(WordCnt+1)-1:0] kidx_q;
  logic [7:0]   rcon_q;
  logic [31:0]  kw_half_q;       // first 32-bit half waiting for pair

  // round key RAM
  logic              ram_we;
  logic [RkAw-1:0]   ram_waddr, ram_raddr;
  logic [63:0]       ram_wdata, ram_rdata;

  aes256cfb_ram #(.Width(64), .Depth(RkDepth)) u_rk (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o  = (state_q != aes256cfb_pkg::ST_IDLE);
  assign out_valid_o = (state_q == aes256cfb_pkg::ST_OUT);
  assign out_data_o  = '{result_high: resh_q, result_low: resl_q};

  // next key word
  logic [31:0] knew;
  logic [31:0] kt;
  always_comb begin
    kt = kw_q[7];
    if (kidx_q[2:0] == 3'd0) begin
      kt = aes256cfb_pkg::sub_word({kw_q[7][23:0], kw_q[7][31:24]}) ^ {rcon_q, 24'd0};
    end else if (kidx_q[2:0] == 3'd4) begin
      kt = aes256cfb_pkg::sub_word(kw_q[7]);
    end
    knew = kw_q[0] ^ kt;
  end

  // words 0..7 are the key itself, later ones are generated
  logic [31:0] kword;
  assign kword = (kidx_q < 8) ? kw_q[kidx_q[2:0]] : knew;

  // round key byte for the byte at the ring head. The RAM word is fetched
  // at the start of each 8-byte half.
  logic [7:0] rk_byte;
  assign rk_byte = ram_rdata[{~bcnt_q[2:0], 3'b111} -: 8];

  // ShiftRows: byte i of the new state comes from old byte ((c+r)&3)*4+r.
  // The ring rotates left by one byte a cycle; new bytes enter at the tail.
  // Source index relative to the unshifted state is fixed per position;
  // a snapshot of the old state is read out at that index.
  logic [7:0] snap_q [16];
  logic [3:0] src_idx;
  logic [1:0] sr_c, sr_r;
  assign sr_c = bcnt_q[3:2];
  assign sr_r = bcnt_q[1:0];
  assign src_idx = {sr_c + sr_r, sr_r};

  logic [7:0] sub_byte;
  assign sub_byte = aes256cfb_pkg::SBOX[snap_q[src_idx]];

  // MixColumns on the column at the head (4 bytes)
  logic [7:0] a0, a1, a2, a3, all_x;
  assign a0 = st_q[0];
  assign a1 = st_q[1];
  assign a2 = st_q[2];
  assign a3 = st_q[3];
  assign all_x = a0 ^ a1 ^ a2 ^ a3;

  logic last_rnd;
  assign last_rnd = (rnd_q == RndW'(Rounds));

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = kidx_q[RkAw:1];
    ram_wdata = {kw_half_q, kword};
    ram_raddr = RkAw'({rnd_q, 1'b0}) + RkAw'(bcnt_q[3] ^ (bcnt_q[2:0] == 3'd7));
    case (state_q)
      aes256cfb_pkg::ST_IDLE:  if (in_acc) begin
        state_d = in_data_i.first_block ? aes256cfb_pkg::ST_KEXP
                                        : aes256cfb_pkg::ST_ROUND;
      end
      aes256cfb_pkg::ST_KEXP: begin
        // odd word index completes a 64-bit pair
        ram_we = kidx_q[0];
        if (kidx_q == WordCnt[$bits(kidx_q)-1:0]) begin
          state_d = aes256cfb_pkg::ST_ROUND;
        end
      end
      aes256cfb_pkg::ST_ROUND: begin
        if (ph_q == aes256cfb_pkg::PH_DONE) state_d = aes256cfb_pkg::ST_OUT;
      end
      aes256cfb_pkg::ST_OUT: if (out_acc) state_d = aes256cfb_pkg::ST_IDLE;
      default: state_d = aes256cfb_pkg::ST_IDLE;
    endcase
  end

  // ph_q during ST_ROUND: fetch wait, ark pass (round 0 or after mix),
  // sub/shift pass, mix pass, key fetch, done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= aes256cfb_pkg::ST_IDLE;
      fbh_q     <= '0;
      fbl_q     <= '0;
      blkh_q    <= '0;
      blkl_q    <= '0;
      resh_q    <= '0;
      resl_q    <= '0;
      bcnt_q    <= '0;
      ph_q      <= aes256cfb_pkg::PH_FETCH;
      rnd_q     <= '0;
      kidx_q    <= '0;
      rcon_q    <= 8'h01;
      kw_half_q <= '0;
      for (int i = 0; i < 16; i++) begin
        st_q[i]   <= '0;
        snap_q[i] <= '0;
      end
      for (int i = 0; i < 8; i++) kw_q[i] <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        aes256cfb_pkg::ST_IDLE: if (in_acc) begin
          blkh_q <= in_data_i.block_high;
          blkl_q <= in_data_i.block_low;
          bcnt_q <= '0;
          ph_q   <= aes256cfb_pkg::PH_FETCH;
          rnd_q  <= '0;
          for (int i = 0; i < 8; i++) begin
            st_q[i]     <= in_data_i.first_block ? ivh_q[8*(7-i) +: 8] : fbh_q[8*(7-i) +: 8];
            st_q[i + 8] <= in_data_i.first_block ? ivl_q[8*(7-i) +: 8] : fbl_q[8*(7-i) +: 8];
          end
          if (in_data_i.first_block) begin
            fbh_q <= ivh_q;
            fbl_q <= ivl_q;
            for (int i = 0; i < 4; i++) begin
              kw_q[2*i]     <= key_q[i][63:32];
              kw_q[2*i + 1] <= key_q[i][31:0];
            end
            kidx_q <= '0;
            rcon_q <= 8'h01;
          end
        end
        aes256cfb_pkg::ST_KEXP: begin
          kw_half_q <= kword;
          kidx_q    <= kidx_q + 1'b1;
          if (kidx_q >= 8) begin
            for (int i = 0; i < 7; i++) kw_q[i] <= kw_q[i + 1];
            kw_q[7] <= knew;
            if (kidx_q[2:0] == 3'd0) rcon_q <= aes256cfb_pkg::xtime(rcon_q);
          end
        end
        aes256cfb_pkg::ST_ROUND: begin
          case (ph_q)
            aes256cfb_pkg::PH_FETCH: begin
              // RAM read of first round-key word is in flight
              ph_q   <= aes256cfb_pkg::PH_ARK;
              bcnt_q <= '0;
            end
            aes256cfb_pkg::PH_ARK: begin
              // AddRoundKey pass
              for (int i = 0; i < 15; i++) st_q[i] <= st_q[i + 1];
              st_q[15] <= st_q[0] ^ rk_byte;
              bcnt_q   <= bcnt_q + 1'b1;
              if (bcnt_q == 4'd15) begin
                if (last_rnd) begin
                  ph_q <= aes256cfb_pkg::PH_DONE;
                end else begin
                  ph_q  <= aes256cfb_pkg::PH_SUB;
                  rnd_q <= rnd_q + 1'b1;
                  for (int i = 0; i < 15; i++) snap_q[i] <= st_q[i + 1];
                  snap_q[15] <= st_q[0] ^ rk_byte;
                end
              end
            end
            aes256cfb_pkg::PH_SUB: begin
              // SubBytes with ShiftRows from the snapshot
              for (int i = 0; i < 15; i++) st_q[i] <= st_q[i + 1];
              st_q[15] <= sub_byte;
              bcnt_q   <= bcnt_q + 1'b1;
              if (bcnt_q == 4'd15) begin
                ph_q <= last_rnd ? aes256cfb_pkg::PH_KEY : aes256cfb_pkg::PH_MIX;
              end
            end
            aes256cfb_pkg::PH_MIX: begin
              // MixColumns, one column a cycle, rotating 4 bytes
              for (int i = 0; i < 12; i++) st_q[i] <= st_q[i + 4];
              st_q[12] <= a0 ^ all_x ^ aes256cfb_pkg::xtime(a0 ^ a1);
              st_q[13] <= a1 ^ all_x ^ aes256cfb_pkg::xtime(a1 ^ a2);
              st_q[14] <= a2 ^ all_x ^ aes256cfb_pkg::xtime(a2 ^ a3);
              st_q[15] <= a3 ^ all_x ^ aes256cfb_pkg::xtime(a3 ^ a0);
              bcnt_q   <= bcnt_q + 4'd4;
              if (bcnt_q == 4'd12) begin
                ph_q   <= aes256cfb_pkg::PH_KEY;
              end
            end
            aes256cfb_pkg::PH_KEY: begin
              // wait for the round-key RAM read
              bcnt_q <= '0;
              ph_q   <= aes256cfb_pkg::PH_ARK;
            end
            aes256cfb_pkg::PH_DONE: begin
              for (int i = 0; i < 8; i++) begin
                resh_q[8*(7-i) +: 8] <= st_q[i] ^ blkh_q[8*(7-i) +: 8];
                resl_q[8*(7-i) +: 8] <= st_q[i + 8] ^ blkl_q[8*(7-i) +: 8];
              end
              if (mode_q) begin
                fbh_q <= blkh_q;
                fbl_q <= blkl_q;
              end else begin
                for (int i = 0; i < 8; i++) begin
                  fbh_q[8*(7-i) +: 8] <= st_q[i] ^ blkh_q[8*(7-i) +: 8];
                  fbl_q[8*(7-i) +: 8] <= st_q[i + 8] ^ blkl_q[8*(7-i) +: 8];
                end
              end
            end
            default: ph_q <= aes256cfb_pkg::PH_FETCH;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Invariant checks
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aes256cfb_pkg::ST_ROUND) |-> in_stall_o)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(resh_q)))
    else $error("result lost under stall");
  a_no_ram_write_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != aes256cfb_pkg::ST_KEXP) |-> !ram_we)
    else $error("round key written outside expansion");

endmodule
